// ===== hdl/b64sd_pkg.sv =====
package b64sd_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_BADCHAR = 2'd2;
  localparam logic [1:0] ST_BADPAD  = 2'd3;

  localparam logic [7:0] PAD_CHAR   = 8'h3d;
  localparam int         QUEUE_DEPTH = 4;
  localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);

  // one completed group or end of run, as handed from front to back
  typedef struct packed {
    logic [23:0] bits;     // three decoded bytes, msb first
    logic [1:0]  nbytes;   // bytes to emit, 0..3
    logic        has_end;  // status transaction follows the bytes
    logic [1:0]  status;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

  // bit 6 set means not an alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = 7'h40;
    if (c >= 8'h41 && c <= 8'h5a) s = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7a) s = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) s = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2b) s = 7'd62;
    else if (c == 8'h2f) s = 7'd63;
    return s;
  endfunction

endpackage

// ===== hdl/b64sd_front.sv =====
module b64sd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic            final_char,
  output b64sd_pkg::q_wr_t wr
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [6:0]  sx;
  logic        is_pad;
  logic        bad_sx;
  logic [5:0]  v;
  logic [1:0]  err_new;
  logic [1:0]  err1;
  logic [1:0]  err2;
  logic [1:0]  pad_inc;
  logic [1:0]  nbytes;
  logic        group_done;

  always_comb begin
    sx      = b64sd_pkg::sextet_of(char_code);
    is_pad  = (char_code == b64sd_pkg::PAD_CHAR);
    bad_sx  = sx[6];
    v       = (is_pad || bad_sx) ? 6'd0 : sx[5:0];
    err_new = b64sd_pkg::ST_OK;
    if (is_pad) begin
      if (pos_r < 2'd2) err_new = b64sd_pkg::ST_BADPAD;
    end else if (pos_r == 2'd3 && pad_r != 2'd0) begin
      err_new = b64sd_pkg::ST_BADPAD;
    end else if (bad_sx) begin
      err_new = b64sd_pkg::ST_BADCHAR;
    end else if (pad_r != 2'd0) begin
      err_new = b64sd_pkg::ST_BADPAD;
    end
    pad_inc = (is_pad && pad_r != 2'd3) ? pad_r + 2'd1 : pad_r;
    err1    = (err_r == b64sd_pkg::ST_OK) ? err_new : err_r;
    group_done = (pos_r == 2'd3);
    err2 = err1;
    // padded group must be the final one
    if (group_done && pad_inc != 2'd0 && !final_char && err1 == b64sd_pkg::ST_OK)
      err2 = b64sd_pkg::ST_BADPAD;

    case (pad_inc)
      2'd0:    nbytes = 2'd3;
      2'd1:    nbytes = 2'd2;
      default: nbytes = 2'd1;
    endcase
    if (!group_done || err2 != b64sd_pkg::ST_OK) nbytes = 2'd0;

    wr.entry.bits    = {acc_r, v};
    wr.entry.nbytes  = nbytes;
    wr.entry.has_end = final_char;
    wr.entry.status  = group_done ? err2 : b64sd_pkg::ST_LENGTH;
    wr.push          = accept && (final_char || nbytes != 2'd0);

    pos_nxt = pos_r;
    acc_nxt = acc_r;
    pad_nxt = pad_r;
    err_nxt = err_r;
    if (accept) begin
      if (final_char) begin
        pos_nxt = 2'd0;
        acc_nxt = 18'd0;
        pad_nxt = 2'd0;
        err_nxt = b64sd_pkg::ST_OK;
      end else if (group_done) begin
        pos_nxt = 2'd0;
        acc_nxt = 18'd0;
        pad_nxt = 2'd0;
        err_nxt = err2;
      end else begin
        pos_nxt = pos_r + 2'd1;
        acc_nxt = {acc_r[11:0], v};
        pad_nxt = pad_inc;
        err_nxt = err2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      acc_r <= 18'd0;
      pad_r <= 2'd0;
      err_r <= b64sd_pkg::ST_OK;
    end else begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      pad_r <= pad_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// ===== hdl/b64sd_queue.sv =====
module b64sd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  b64sd_pkg::q_wr_t wr,
  input  logic             pop,
  output b64sd_pkg::q_rd_t rd,
  output logic             full
);

  b64sd_pkg::entry_t slot_r [b64sd_pkg::QUEUE_DEPTH];

  logic [b64sd_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [b64sd_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [b64sd_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    full     = (cnt_r == (b64sd_pkg::QPTR_W+1)'(b64sd_pkg::QUEUE_DEPTH));
    rd.valid = (cnt_r != '0);
    rd.entry = slot_r[rptr_r];
    wptr_nxt = wr.push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (wr.push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!wr.push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr.push) slot_r[wptr_r] <= wr.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/b64sd_back.sv =====
module b64sd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  b64sd_pkg::q_rd_t rd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic             out_has_data,
  output logic             out_end_of_run,
  output logic [1:0]       out_status
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       has_r, has_nxt;
  logic       end_r, end_nxt;
  logic [1:0] st_r, st_nxt;

  logic       load;
  logic [2:0] n_items;
  logic       last_item;
  logic       is_byte;

  always_comb begin
    load      = rd.valid && (!valid_r || !out_stall);
    n_items   = {1'b0, rd.entry.nbytes} + {2'b00, rd.entry.has_end};
    last_item = ({1'b0, idx_r} + 3'd1 == n_items);
    is_byte   = (idx_r < rd.entry.nbytes);
    pop       = load && last_item;

    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    has_nxt   = has_r;
    end_nxt   = end_r;
    st_nxt    = st_r;
    if (valid_r && !out_stall) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_item ? 2'd0 : idx_r + 2'd1;
      if (is_byte) begin
        case (idx_r)
          2'd0:    byte_nxt = rd.entry.bits[23:16];
          2'd1:    byte_nxt = rd.entry.bits[15:8];
          default: byte_nxt = rd.entry.bits[7:0];
        endcase
        has_nxt = 1'b1;
        end_nxt = 1'b0;
        st_nxt  = b64sd_pkg::ST_OK;
      end else begin
        byte_nxt = 8'd0;
        has_nxt  = 1'b0;
        end_nxt  = 1'b1;
        st_nxt   = rd.entry.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    has_r  <= has_nxt;
    end_r  <= end_nxt;
    st_r   <= st_nxt;
  end

  assign out_valid      = valid_r;
  assign out_data_byte  = byte_r;
  assign out_has_data   = has_r;
  assign out_end_of_run = end_r;
  assign out_status     = st_r;

endmodule

// ===== hdl/base64_strict_decoder_top.sv =====
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_char_code[7:0], in_final_char
// out_      output     out_valid/out_stall  out_data_byte[7:0], out_has_data,
//                                           out_end_of_run, out_status[1:0]
//
// one character transaction per cycle is taken while the group queue has room
// a completed group goes into a queue slot, then each byte or status transaction
// passes through the output register, one a cycle while out_stall is low
// rst_n is synchronous, active low; it empties the queue and clears the group
// out_stall only backs up the queue; in_stall rises once all four slots are full
module base64_strict_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  // character transactions
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  // decoded byte and status transactions
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_has_data,
  output logic       out_end_of_run,
  output logic [1:0] out_status
);

  b64sd_pkg::q_wr_t wr;
  b64sd_pkg::q_rd_t rd;
  logic             q_full;
  logic             pop;
  logic             accept;

  // stall depends only on queue occupancy, never on in_valid
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // front: sextet lookup, padding checks, group accumulation
  b64sd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .char_code  (in_char_code),
    .final_char (in_final_char),
    .wr         (wr)
  );

  // short queue of completed groups and end-of-run status
  b64sd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (pop),
    .rd    (rd),
    .full  (q_full)
  );

  // back: splits each queue entry into byte and status transactions
  b64sd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd             (rd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_has_data   (out_has_data),
    .out_end_of_run (out_end_of_run),
    .out_status     (out_status)
  );

endmodule
